/* design/scaa_pkg.sv */
package scaa_pkg;

   localparam int MAX_VECTORS_DEF = 32;
   localparam int MAX_LAGS_DEF    = 256;

   // configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] REG_INV_BOX   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VEC_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_COUNT = 2'd2;

   localparam logic [23:0] INV_BOX_RESET   = 24'd0;
   localparam logic [5:0]  VEC_COUNT_RESET = 6'd1;
   localparam logic [16:0] INV_COUNT_ONE   = 17'd65536;

   // cosine polynomial, Q30
   localparam logic [30:0] CC2   = 31'd1324675889;
   localparam logic [30:0] CC4   = 31'd272375564;
   localparam logic [30:0] CC6   = 31'd22401987;
   localparam logic [30:0] CC8   = 31'd987049;
   localparam logic [30:0] ONE30 = 31'd1073741824;

   localparam logic signed [47:0] FS_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] FS_MIN = 48'sh8000_0000_0000;
   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic signed [63:0] first_sum;
      logic signed [63:0] second_sum;
   } lag_sums_type;

   // coefficient for Horner step i (innermost first)
   function automatic logic [30:0] horner_coef(input logic [1:0] i);
      logic [30:0] c;
      case (i)
         2'd0:    c = CC6;
         2'd1:    c = CC4;
         2'd2:    c = CC2;
         default: c = ONE30;
      endcase
      return c;
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

endpackage

/* design/scaa_if.sv */
interface scaa_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] cur_x;
   logic signed [31:0] cur_y;
   logic signed [31:0] cur_z;
   logic signed [31:0] ref_x;
   logic signed [31:0] ref_y;
   logic signed [31:0] ref_z;
   logic        [7:0]  lag_index;
   logic               last_particle;
   logic signed [5:0]  wave_kx;
   logic signed [5:0]  wave_ky;
   logic signed [5:0]  wave_kz;

   modport source (output valid, kind, cur_x, cur_y, cur_z, ref_x, ref_y, ref_z,
                   lag_index, last_particle, wave_kx, wave_ky, wave_kz,
                   input ready);
   modport sink (input valid, kind, cur_x, cur_y, cur_z, ref_x, ref_y, ref_z,
                 lag_index, last_particle, wave_kx, wave_ky, wave_kz,
                 output ready);
endinterface

interface scaa_rsp_if;
   logic               valid;
   logic               ready;
   logic        [7:0]  lag_slot;
   logic signed [47:0] frame_mean;
   logic signed [63:0] first_sum;
   logic signed [63:0] second_sum;

   modport source (output valid, lag_slot, frame_mean, first_sum, second_sum,
                   input ready);
   modport sink (input valid, lag_slot, frame_mean, first_sum, second_sum,
                 output ready);
endinterface

interface scaa_csr_if;
   logic                               valid;
   logic                               ready;
   logic [scaa_pkg::CSR_IDX_W-1:0]     index;
   logic [scaa_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/scattering_cosine_accumulator_unit.sv */
// Scattering cosine accumulator.
// req_if takes two kinds of item: a load item appends one wavevector to the
// table unless it is full (ready again the next cycle); a particle item adds one
// cosine term per used wavevector to the frame sum. A particle marked last
// also folds the frame mean into the per-lag sums and sends one transfer on
// rsp_if carrying the lag slot, the mean and both updated sums.
// csr_if writes the three registers; it is always ready. It is to be written
// only while the block is idle; the block itself does not enforce this.
// Sequence: after the transfer, each wavevector goes through ST_RD (fetch the
// vector), ST_DOT0 to ST_DOT2 and ST_PHASE (form the phase on the shared
// multiplier) and ST_COS (the iterative cosine unit); ST_LAST then closes.
// A last particle goes on through lag check, mean, three-part square and sum
// update, with a lag reduction step in ST_LAGMOD while the lag is not below
// MAX_LAGS. req_if.ready is low for that whole time.
// Reset: all control state clears, then a clearing pass zeroes all MAX_LAGS
// per-lag sums; req_if.ready stays low during the pass.
// A stalled rsp_if holds its result; a new particle is still accepted, but a
// last particle then holds in ST_UPDATE until the previous result has gone.
module scattering_cosine_accumulator_unit #(
   parameter int MAX_VECTORS = scaa_pkg::MAX_VECTORS_DEF,
   parameter int MAX_LAGS    = scaa_pkg::MAX_LAGS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   scaa_req_if.sink    req_if,
   scaa_rsp_if.source  rsp_if,
   scaa_csr_if.sink    csr_if
);

   localparam int KW    = $clog2(MAX_VECTORS + 1);
   localparam int TW    = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int LAG_W = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_RD     = 4'd2;
   localparam logic [3:0] ST_DOT0   = 4'd3;
   localparam logic [3:0] ST_DOT1   = 4'd4;
   localparam logic [3:0] ST_DOT2   = 4'd5;
   localparam logic [3:0] ST_PHASE  = 4'd6;
   localparam logic [3:0] ST_COS    = 4'd7;
   localparam logic [3:0] ST_LAST   = 4'd8;
   localparam logic [3:0] ST_LAGMOD = 4'd9;
   localparam logic [3:0] ST_MEAN   = 4'd10;
   localparam logic [3:0] ST_SQ0    = 4'd11;
   localparam logic [3:0] ST_SQ1    = 4'd12;
   localparam logic [3:0] ST_SQ2    = 4'd13;
   localparam logic [3:0] ST_UPDATE = 4'd14;

   logic [3:0]          state_ff, state_in;
   logic [23:0]         ibt_ff, ibt_in;
   logic [5:0]          vc_ff, vc_in;
   logic [16:0]         ivc_ff, ivc_in;
   logic [KW-1:0]       ptr_ff, ptr_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [KW-1:0]       n_ff, n_in;
   logic [LAG_W-1:0]    clr_ff, clr_in;
   logic signed [32:0]  dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [7:0]          lag_ff, lag_in;
   logic                last_ff, last_in;
   logic signed [41:0]  dot_ff, dot_in;
   logic signed [47:0]  fs_ff, fs_in;
   logic signed [47:0]  mean_ff, mean_in;
   logic [63:0]         sq_ff, sq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_lag_ff, rsp_lag_in;
   logic signed [47:0]  rsp_mean_ff, rsp_mean_in;
   logic signed [63:0]  rsp_first_ff, rsp_first_in;
   logic signed [63:0]  rsp_second_ff, rsp_second_in;

   logic [17:0]         tbl_mem [MAX_VECTORS];
   logic [17:0]         tbl_q;
   scaa_pkg::lag_sums_type sums_mem [MAX_LAGS];
   scaa_pkg::lag_sums_type sums_q;

   logic                   tbl_we;
   logic                   sums_we;
   logic [LAG_W-1:0]       sums_waddr;
   scaa_pkg::lag_sums_type sums_wdata;
   logic [LAG_W-1:0]       lag_addr;

   logic signed [48:0]  mul_a;
   logic signed [24:0]  mul_b;
   logic signed [73:0]  prod;
   logic [16:0]         ivc_eff;
   logic [47:0]         m_abs;
   logic                m_big;
   logic [23:0]         m_hi;
   logic [14:0]         m_lo;
   logic signed [48:0]  fs_sum;
   logic [KW-1:0]       n_req;
   logic                req_fire;
   logic                rsp_free;
   logic                cos_start, cos_done;
   logic signed [15:0]  cos_val;
   logic signed [63:0]  sq_val;

   scaa_cos u_cos (
      .clock (clock),
      .reset (reset),
      .start (cos_start),
      .phase (prod[39:24]),
      .done  (cos_done),
      .value (cos_val)
   );

   assign req_fire      = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign csr_if.ready  = 1'b1;
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;
   assign cos_start     = (state_ff == ST_PHASE);
   assign lag_addr      = LAG_W'(lag_ff);

   always_comb begin
      ivc_eff = (ivc_ff > scaa_pkg::INV_COUNT_ONE) ? scaa_pkg::INV_COUNT_ONE : ivc_ff;
      m_abs   = mean_ff[47] ? 48'(-mean_ff) : 48'(mean_ff);
      m_big   = |m_abs[47:39];
      m_hi    = m_abs[38:15];
      m_lo    = m_abs[14:0];
      n_req   = ({1'b0, vc_ff} > 7'(MAX_VECTORS)) ? KW'(MAX_VECTORS) : KW'(vc_ff);
      fs_sum  = 49'(fs_ff) + 49'(cos_val);
      sq_val  = m_big ? scaa_pkg::S64_MAX : $signed(sq_ff);
   end

   // shared multiplier: dot product, phase scale, mean and square parts
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_DOT0: begin
            mul_a = 49'(dx_ff);
            mul_b = 25'($signed(tbl_q[17:12]));
         end
         ST_DOT1: begin
            mul_a = 49'(dy_ff);
            mul_b = 25'($signed(tbl_q[11:6]));
         end
         ST_DOT2: begin
            mul_a = 49'(dz_ff);
            mul_b = 25'($signed(tbl_q[5:0]));
         end
         ST_PHASE: begin
            mul_a = 49'(dot_ff);
            mul_b = $signed({1'b0, ibt_ff});
         end
         ST_MEAN: begin
            mul_a = 49'(fs_ff);
            mul_b = $signed({8'd0, ivc_eff});
         end
         ST_SQ0: begin
            mul_a = $signed({34'd0, m_lo});
            mul_b = $signed({10'd0, m_lo});
         end
         ST_SQ1: begin
            mul_a = $signed({25'd0, m_hi});
            mul_b = $signed({10'd0, m_lo});
         end
         ST_SQ2: begin
            mul_a = $signed({25'd0, m_hi});
            mul_b = $signed({1'b0, m_hi});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = mul_a * mul_b;
   end

   always_comb begin
      state_in      = state_ff;
      ibt_in        = ibt_ff;
      vc_in         = vc_ff;
      ivc_in        = ivc_ff;
      ptr_in        = ptr_ff;
      k_in          = k_ff;
      n_in          = n_ff;
      clr_in        = clr_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dz_in         = dz_ff;
      lag_in        = lag_ff;
      last_in       = last_ff;
      dot_in        = dot_ff;
      fs_in         = fs_ff;
      mean_in       = mean_ff;
      sq_in         = sq_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_lag_in    = rsp_lag_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      tbl_we        = 1'b0;
      sums_we       = 1'b0;
      sums_waddr    = lag_addr;
      sums_wdata    = '0;

      if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            scaa_pkg::REG_INV_BOX:   ibt_in = csr_if.data;
            scaa_pkg::REG_VEC_COUNT: vc_in  = csr_if.data[5:0];
            scaa_pkg::REG_INV_COUNT: ivc_in = csr_if.data[16:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            sums_we    = 1'b1;
            sums_waddr = clr_ff;
            if (clr_ff == LAG_W'(MAX_LAGS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.kind) begin
                  if (ptr_ff != KW'(MAX_VECTORS)) begin
                     tbl_we = 1'b1;
                     ptr_in = ptr_ff + 1'b1;
                  end
               end else begin
                  dx_in   = 33'(req_if.cur_x) - 33'(req_if.ref_x);
                  dy_in   = 33'(req_if.cur_y) - 33'(req_if.ref_y);
                  dz_in   = 33'(req_if.cur_z) - 33'(req_if.ref_z);
                  lag_in  = req_if.lag_index;
                  last_in = req_if.last_particle;
                  k_in    = '0;
                  n_in    = n_req;
                  state_in = (n_req == '0) ? ST_LAST : ST_RD;
               end
            end
         end
         ST_RD:    state_in = ST_DOT0;
         ST_DOT0: begin
            dot_in   = prod[41:0];
            state_in = ST_DOT1;
         end
         ST_DOT1: begin
            dot_in   = dot_ff + prod[41:0];
            state_in = ST_DOT2;
         end
         ST_DOT2: begin
            dot_in   = dot_ff + prod[41:0];
            state_in = ST_PHASE;
         end
         ST_PHASE: state_in = ST_COS;
         ST_COS: begin
            if (cos_done) begin
               if (fs_sum[48] != fs_sum[47]) begin
                  fs_in = fs_sum[48] ? scaa_pkg::FS_MIN : scaa_pkg::FS_MAX;
               end else begin
                  fs_in = fs_sum[47:0];
               end
               if (k_ff + 1'b1 == n_ff) begin
                  state_in = ST_LAST;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         ST_LAST:  state_in = last_ff ? ST_LAGMOD : ST_IDLE;
         ST_LAGMOD: begin
            // reduce the lag one subtraction at a time
            if (13'(lag_ff) >= 13'(MAX_LAGS)) begin
               lag_in = lag_ff - 8'(MAX_LAGS);
            end else begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            mean_in  = prod[63:16];
            state_in = ST_SQ0;
         end
         ST_SQ0: begin
            sq_in    = {49'd0, prod[29:15]};
            state_in = ST_SQ1;
         end
         ST_SQ1: begin
            sq_in    = sq_ff + {24'd0, prod[38:0], 1'b0};
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            sq_in    = sq_ff + {prod[48:0], 15'd0};
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the output register is free
            if (rsp_free) begin
               sums_we               = 1'b1;
               sums_wdata.first_sum  = scaa_pkg::sat_add64(sums_q.first_sum, 64'(mean_ff));
               sums_wdata.second_sum = scaa_pkg::sat_add64(sums_q.second_sum, sq_val);
               rsp_valid_in          = 1'b1;
               rsp_lag_in            = lag_ff;
               rsp_mean_in           = mean_ff;
               rsp_first_in          = sums_wdata.first_sum;
               rsp_second_in         = sums_wdata.second_sum;
               fs_in                 = '0;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[TW'(ptr_ff)] <= {req_if.wave_kx, req_if.wave_ky, req_if.wave_kz};
      end
      tbl_q <= tbl_mem[TW'(k_ff)];
   end

   always_ff @(posedge clock) begin
      if (sums_we) begin
         sums_mem[sums_waddr] <= sums_wdata;
      end
      sums_q <= sums_mem[lag_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ibt_ff       <= scaa_pkg::INV_BOX_RESET;
         vc_ff        <= scaa_pkg::VEC_COUNT_RESET;
         ivc_ff       <= scaa_pkg::INV_COUNT_ONE;
         ptr_ff       <= '0;
         k_ff         <= '0;
         n_ff         <= '0;
         fs_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ibt_ff       <= ibt_in;
         vc_ff        <= vc_in;
         ivc_ff       <= ivc_in;
         ptr_ff       <= ptr_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         fs_ff        <= fs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      dz_ff         <= dz_in;
      lag_ff        <= lag_in;
      last_ff       <= last_in;
      dot_ff        <= dot_in;
      mean_ff       <= mean_in;
      sq_ff         <= sq_in;
      rsp_lag_ff    <= rsp_lag_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.lag_slot   = rsp_lag_ff;
   assign rsp_if.frame_mean = rsp_mean_ff;
   assign rsp_if.first_sum  = rsp_first_ff;
   assign rsp_if.second_sum = rsp_second_ff;

endmodule

/* design/scaa_cos.sv */
// Iterative cosine of a 16-bit turn phase, Q1.15 result.
module scaa_cos (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        phase,
   output logic               done,
   output logic signed [15:0] value
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [2:0]        step_ff, step_in;
   logic [1:0]        quad_ff, quad_in;
   logic [14:0]       u_ff, u_in;
   logic [30:0]       x2_ff, x2_in;
   logic [30:0]       p_ff, p_in;
   logic signed [15:0] value_ff, value_in;

   logic [30:0] mul_a, mul_b;
   logic [61:0] prod;
   logic [31:0] t;
   logic [30:0] c;
   logic [16:0] rnd;
   logic [15:0] mag;

   always_comb begin
      mul_a = (step_ff == 3'd0) ? 31'(u_ff) : p_ff;
      mul_b = (step_ff == 3'd0) ? 31'(u_ff) : x2_ff;
      prod  = mul_a * mul_b;
      t     = prod[61:30];
      c     = scaa_pkg::horner_coef(2'(step_ff - 3'd1));
      rnd   = 17'((32'(p_ff) + 32'd16384) >> 15);
      mag   = (rnd > 17'd32767) ? 16'd32767 : rnd[15:0];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      quad_in  = quad_ff;
      u_in     = u_ff;
      x2_in    = x2_ff;
      p_in     = p_ff;
      value_in = value_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         quad_in = phase[15:14];
         u_in    = phase[14] ? (15'd16384 - 15'(phase[13:0])) : 15'(phase[13:0]);
         p_in    = scaa_pkg::CC8;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd0) begin
            x2_in = {prod[28:0], 2'b00};
         end else if (step_ff == 3'd5) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            value_in = (quad_ff == 2'd1 || quad_ff == 2'd2) ? -$signed(mag) : $signed(mag);
         end else begin
            p_in = (t > 32'(c)) ? 31'd0 : 31'(32'(c) - t);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quad_ff  <= quad_in;
      u_ff     <= u_in;
      x2_ff    <= x2_in;
      p_ff     <= p_in;
      value_ff <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

/* design/scaa_checker.sv */
module scaa_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_kind,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         rsp_lag_slot,
   input logic signed [47:0] rsp_frame_mean,
   input logic signed [63:0] rsp_first_sum,
   input logic signed [63:0] rsp_second_sum
);

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req ready during clearing pass");

   // a particle occupies the block: ready is low right after its transfer
   a_particle_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_kind) |=> !req_ready)
      else $error("ready right after a particle transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_lag_slot) && $stable(rsp_frame_mean)
         && $stable(rsp_first_sum) && $stable(rsp_second_sum)))
      else $error("result changed while stalled");

endmodule

bind scattering_cosine_accumulator_unit scaa_checker u_scaa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_kind       (req_if.kind),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_lag_slot   (rsp_if.lag_slot),
   .rsp_frame_mean (rsp_if.frame_mean),
   .rsp_first_sum  (rsp_if.first_sum),
   .rsp_second_sum (rsp_if.second_sum)
);
